// ===== sv/bam_pkg.sv =====
// bam_pkg: shared types and constants for the block average mosaic.
// No dependencies; used by every design module of the block.
`default_nettype none
package bam_pkg;
  localparam int SumBits = 27;
  localparam int MaxAcross = 256;
  localparam int IdxBits = 8;
  localparam int TotBits = 19;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegAcross = 2'd2;
  localparam logic [1:0] RegDown   = 2'd3;

  // work handed from front to back
  typedef struct packed {
    logic [IdxBits-1:0] idx;
    logic               first;
    logic               emit;
    logic [7:0]         bcol;
    logic [7:0]         brow;
    logic               fdone;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } cmd_t;
endpackage
`default_nettype wire

// ===== sv/bam_front.sv =====
// bam_front: position counters; classifies each pixel into a command.
// Depends on bam_pkg.
`default_nettype none
module bam_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  input  wire logic        frame_start,
  input  wire logic [9:0]  bw,
  input  wire logic [8:0]  bh,
  input  wire logic [8:0]  ba,
  input  wire logic [8:0]  bd,
  output bam_pkg::cmd_t    cmd
);
  logic [9:0] col_in_block;
  logic [8:0] row_in_block;
  logic [7:0] cur_block_col, cur_block_row;
  logic [9:0] cib;
  logic [8:0] rib;
  logic [7:0] cbc, cbr;
  logic       last_col, last_row, end_col, end_row;

  always_comb begin
    cib = frame_start ? '0 : col_in_block;
    rib = frame_start ? '0 : row_in_block;
    cbc = frame_start ? '0 : cur_block_col;
    cbr = frame_start ? '0 : cur_block_row;
    last_col = cib >= bw - 10'd1;
    last_row = rib >= bh - 9'd1;
    end_col  = {1'b0, cbc} >= ba - 9'd1;
    end_row  = {1'b0, cbr} >= bd - 9'd1;
    cmd.idx   = cbc;
    cmd.first = (cib == '0) && (rib == '0);
    cmd.emit  = last_col && last_row;
    cmd.bcol  = cbc;
    cmd.brow  = cbr;
    cmd.fdone = end_col && end_row;
    cmd.r = red;
    cmd.g = green;
    cmd.b = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_in_block <= '0;
      row_in_block <= '0;
      cur_block_col <= '0;
      cur_block_row <= '0;
    end else if (take) begin
      col_in_block <= cib;
      row_in_block <= rib;
      cur_block_col <= cbc;
      cur_block_row <= cbr;
      if (last_col) begin
        col_in_block <= '0;
        if (end_col) begin
          cur_block_col <= '0;
          if (last_row) begin
            row_in_block <= '0;
            cur_block_row <= end_row ? 8'd0 : cbr + 8'd1;
          end else begin
            row_in_block <= rib + 9'd1;
          end
        end else begin
          cur_block_col <= cbc + 8'd1;
        end
      end else begin
        col_in_block <= cib + 10'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/bam_fifo.sv =====
// bam_fifo: two-entry command queue between front and back.
// Depends on bam_pkg.
`default_nettype none
module bam_fifo (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire bam_pkg::cmd_t din,
  output logic          full,
  input  wire logic     pop,
  output bam_pkg::cmd_t dout,
  output logic          nonempty
);
  bam_pkg::cmd_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/bam_div.sv =====
// bam_div: iterative restoring divider, 8-bit saturated quotient.
// Depends on bam_pkg.
`default_nettype none
module bam_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bam_pkg::SumBits-1:0] num,
  input  wire logic [bam_pkg::TotBits-1:0] den,
  output logic                             done,
  output logic [7:0]                       quo
);
  localparam int N = bam_pkg::SumBits;
  logic           busy;
  logic [N-1:0]   q;
  logic [N:0]     rem;
  logic [4:0]     cnt;
  logic [N:0]     trial;
  logic [N:0]     dext;

  assign dext  = {{(N+1-bam_pkg::TotBits){1'b0}}, den};
  assign trial = {rem[N-1:0], q[N-1]};
  assign quo   = (|q[N-1:8]) ? 8'hFF : q[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        rem <= '0;
        cnt <= 5'(N - 1);
      end else if (busy) begin
        if (trial >= dext) begin
          rem <= trial - dext;
          q <= {q[N-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[N-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/bam_back.sv =====
// bam_back: sum memories, accumulate, divide and output register.
// Depends on bam_pkg and bam_div.
`default_nettype none
module bam_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          avail,
  input  wire bam_pkg::cmd_t cmd,
  output logic               pop,
  input  wire logic [bam_pkg::TotBits-1:0] total,
  output logic               valid,
  input  wire logic          stall,
  output logic [7:0]         block_col,
  output logic [7:0]         block_row,
  output logic [7:0]         avg_red,
  output logic [7:0]         avg_green,
  output logic [7:0]         avg_blue,
  output logic               frame_done
);
  localparam int N = bam_pkg::SumBits;
  typedef enum logic [2:0] {S_IDLE, S_READ, S_WRITE, S_DR, S_DG, S_DB, S_OUT} st_t;
  st_t state;
  logic [N-1:0] rmem [bam_pkg::MaxAcross];
  logic [N-1:0] gmem [bam_pkg::MaxAcross];
  logic [N-1:0] bmem [bam_pkg::MaxAcross];
  logic [N-1:0] rd_r, rd_g, rd_b, sr, sg, sb, dnum;
  bam_pkg::cmd_t c;
  logic dstart, ddone;
  logic [7:0] dq, qr, qg, qb;

  assign pop = (state == S_IDLE) && avail;

  // after the write, rd_g and rd_b hold the new green and blue sums
  always_ff @(posedge clk) begin
    rd_r <= rmem[c.idx];
    rd_g <= gmem[c.idx];
    rd_b <= bmem[c.idx];
    if (state == S_WRITE) begin
      rmem[c.idx] <= sr;
      gmem[c.idx] <= sg;
      bmem[c.idx] <= sb;
    end
  end

  always_comb begin
    sr = (c.first ? '0 : rd_r) + N'(c.r);
    sg = (c.first ? '0 : rd_g) + N'(c.g);
    sb = (c.first ? '0 : rd_b) + N'(c.b);
  end

  bam_div u_div (.clk, .rst, .start(dstart), .num(dnum), .den(total),
                 .done(ddone), .quo(dq));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      if (valid && !stall) valid <= 1'b0;
      unique case (state)
        S_IDLE: if (pop) begin
          c <= cmd;
          state <= S_READ;
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          dnum <= sr;
          if (c.emit) begin
            dstart <= 1'b1;
            state <= S_DR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DR: if (ddone) begin
          qr <= dq;
          dnum <= rd_g;
          dstart <= 1'b1;
          state <= S_DG;
        end
        S_DG: if (ddone) begin
          qg <= dq;
          dnum <= rd_b;
          dstart <= 1'b1;
          state <= S_DB;
        end
        S_DB: if (ddone) begin
          qb <= dq;
          state <= S_OUT;
        end
        S_OUT: if (!valid || !stall) begin
          valid <= 1'b1;
          block_col <= c.bcol;
          block_row <= c.brow;
          avg_red <= qr;
          avg_green <= qg;
          avg_blue <= qb;
          frame_done <= c.fdone;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/block_average_mosaic_top.sv =====
// block_average_mosaic_top: block-average pixelation, top level.
// Depends on bam_pkg, bam_front, bam_fifo, bam_back.
//
//  channel  | signals                                   | flow
//  pixel    | valid/stall, red green blue frame_start   | in
//  block    | out_valid/out_stall, block_col .. done    | out
//  config   | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//
// A pixel passes through the back end in order (memory read, accumulate,
// write); a finishing pixel adds three divides (load, 27 steps, handoff)
// in the shared divider, then loads the output register.
// The front takes a pixel per cycle until the two-entry queue fills.
// Reset is synchronous; the sum memories are not cleared.
`default_nettype none
module block_average_mosaic_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       valid,
  output logic            stall,
  input  wire logic [7:0] red,
  input  wire logic [7:0] green,
  input  wire logic [7:0] blue,
  input  wire logic       frame_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      block_col,
  output logic [7:0]      block_row,
  output logic [7:0]      avg_red,
  output logic [7:0]      avg_green,
  output logic [7:0]      avg_blue,
  output logic            frame_done,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [9:0] cfg_data
);
  logic [9:0] block_width, bw;
  logic [8:0] block_height, blocks_across, blocks_down, bh, ba, bd;
  logic [bam_pkg::TotBits-1:0] total;
  bam_pkg::cmd_t fcmd, qcmd;
  logic full, nonempty, pop, take;

  assign cfg_ready = 1'b1;
  assign stall = full;
  assign take = valid && !full;

  always_comb begin
    bw = (block_width == '0) ? 10'd1 : block_width;
    bh = (block_height == '0) ? 9'd1 : block_height;
    ba = (blocks_across == '0) ? 9'd1 : blocks_across;
    bd = (blocks_down == '0) ? 9'd1 : blocks_down;
    if (ba > 9'd256) ba = 9'd256;
    if (bd > 9'd256) bd = 9'd256;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_width <= 10'd20;
      block_height <= 9'd15;
      blocks_across <= 9'd32;
      blocks_down <= 9'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bam_pkg::RegWidth:  block_width <= cfg_data;
        bam_pkg::RegHeight: block_height <= cfg_data[8:0];
        bam_pkg::RegAcross: blocks_across <= cfg_data[8:0];
        bam_pkg::RegDown:   blocks_down <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    total <= bam_pkg::TotBits'(bw * bh);
  end

  bam_front u_front (.clk, .rst, .take, .red, .green, .blue, .frame_start,
                     .bw, .bh, .ba, .bd, .cmd(fcmd));
  bam_fifo u_fifo (.clk, .rst, .push(take), .din(fcmd), .full, .pop, .dout(qcmd),
                   .nonempty);
  bam_back u_back (.clk, .rst, .avail(nonempty), .cmd(qcmd), .pop, .total,
                   .valid(out_valid), .stall(out_stall), .block_col, .block_row,
                   .avg_red, .avg_green, .avg_blue, .frame_done);
endmodule
`default_nettype wire

// ===== sv/bam_checker.sv =====
// bam_props: port-level checks for block_average_mosaic_top.
// Depends on nothing; bound to the top level below.
`default_nettype none
module bam_props (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] block_col,
  input wire logic       frame_done,
  input wire logic       cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({block_col, frame_done}))
    else $error("held");
  a_cfg: assert property (@(posedge clk) cfg_ready) else $error("cfg");
  a_rst: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("rst");
endmodule
bind block_average_mosaic_top bam_props u_chk (.clk, .rst, .out_valid, .out_stall,
  .block_col, .frame_done, .cfg_ready);
`default_nettype wire

// ===== dv/bam_checker.sv =====
// bam_checker: watches the pixel, block and config channels of the mosaic,
// predicts each finished block and compares it field by field.
// Depends on bam_pkg for the register index constants and sizes.
module bam_checker
  import bam_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  input  logic       stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       frame_start,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] block_col,
  input  logic [7:0] block_row,
  input  logic [7:0] avg_red,
  input  logic [7:0] avg_green,
  input  logic [7:0] avg_blue,
  input  logic       frame_done,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  output int         errors,
  output int         pending,
  output int         pixels_seen,
  output int         blocks_seen
);
  typedef struct {
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       done;
  } block_avg_t;

  block_avg_t         avg_q[$];
  logic [9:0]         blk_w;
  logic [8:0]         blk_h;
  logic [8:0]         across;
  logic [8:0]         down;
  logic [9:0]         px_col;
  logic [8:0]         px_row;
  logic [7:0]         bcol;
  logic [7:0]         brow;
  logic [TotBits-1:0] pix_total;
  logic [SumBits-1:0] sum_r[MaxAcross];
  logic [SumBits-1:0] sum_g[MaxAcross];
  logic [SumBits-1:0] sum_b[MaxAcross];

  function automatic int at_least_one(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic [7:0] mean_of(logic [SumBits-1:0] s);
    int unsigned t, q;
    t = (pix_total == '0) ? 1 : 32'(pix_total);
    q = 32'(s) / t;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic void retotal();
    int unsigned p;
    p = at_least_one(32'(blk_w)) * at_least_one(32'(blk_h));
    pix_total = p[TotBits-1:0];
  endfunction

  function automatic void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic fs);
    int ew, eh, ea, ed, i;
    logic lc, lr;
    block_avg_t e;
    ew = at_least_one(32'(blk_w));
    eh = at_least_one(32'(blk_h));
    ea = at_least_one(32'(across));
    if (ea > MaxAcross) ea = MaxAcross;
    ed = at_least_one(32'(down));
    if (ed > 256) ed = 256;
    if (fs) begin
      px_col = '0;
      px_row = '0;
      bcol = '0;
      brow = '0;
    end
    i = 32'(bcol);
    if (px_col == '0 && px_row == '0) begin
      sum_r[i] = SumBits'(r);
      sum_g[i] = SumBits'(g);
      sum_b[i] = SumBits'(b);
    end else begin
      sum_r[i] = sum_r[i] + SumBits'(r);
      sum_g[i] = sum_g[i] + SumBits'(g);
      sum_b[i] = sum_b[i] + SumBits'(b);
    end
    lc = (px_col >= ew - 1);
    lr = (px_row >= eh - 1);
    if (lc && lr) begin
      e.col = bcol;
      e.row = brow;
      e.r = mean_of(sum_r[i]);
      e.g = mean_of(sum_g[i]);
      e.b = mean_of(sum_b[i]);
      e.done = (brow >= ed - 1) && (bcol >= ea - 1);
      avg_q.push_back(e);
    end
    if (lc) begin
      px_col = '0;
      if (bcol >= ea - 1) begin
        bcol = '0;
        if (lr) begin
          px_row = '0;
          brow = (brow >= ed - 1) ? 8'd0 : brow + 8'd1;
        end else begin
          px_row = px_row + 9'd1;
        end
      end else begin
        bcol = bcol + 8'd1;
      end
    end else begin
      px_col = px_col + 10'd1;
    end
  endfunction

  always @(posedge clk) begin
    block_avg_t e;
    if (rst) begin
      blk_w = 10'd20;
      blk_h = 9'd15;
      across = 9'd32;
      down = 9'd32;
      px_col = '0;
      px_row = '0;
      bcol = '0;
      brow = '0;
      retotal();
      avg_q.delete();
      errors = 0;
      pixels_seen = 0;
      blocks_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegWidth: begin
            blk_w = cfg_data;
            retotal();
          end
          RegHeight: begin
            blk_h = cfg_data[8:0];
            retotal();
          end
          RegAcross: across = cfg_data[8:0];
          RegDown: down = cfg_data[8:0];
          default: ;
        endcase
      end
      if (valid && !stall) begin
        take_pixel(red, green, blue, frame_start);
        pixels_seen++;
      end
      if (out_valid && !out_stall) begin
        blocks_seen++;
        if (avg_q.size() == 0) begin
          $error("block transaction with none expected: col %0d row %0d",
                 block_col, block_row);
          errors++;
        end else begin
          e = avg_q.pop_front();
          if (block_col !== e.col) begin
            $error("block_col expected %0d actual %0d", e.col, block_col);
            errors++;
          end
          if (block_row !== e.row) begin
            $error("block_row expected %0d actual %0d", e.row, block_row);
            errors++;
          end
          if (avg_red !== e.r) begin
            $error("avg_red expected %0d actual %0d", e.r, avg_red);
            errors++;
          end
          if (avg_green !== e.g) begin
            $error("avg_green expected %0d actual %0d", e.g, avg_green);
            errors++;
          end
          if (avg_blue !== e.b) begin
            $error("avg_blue expected %0d actual %0d", e.b, avg_blue);
            errors++;
          end
          if (frame_done !== e.done) begin
            $error("frame_done expected %0d actual %0d", e.done, frame_done);
            errors++;
          end
        end
      end
    end
    pending = avg_q.size();
  end
endmodule

// ===== dv/tb.sv =====
// tb: stimulus and verdict for block_average_mosaic_top.
// Depends on bam_pkg, the block's RTL and bam_checker.
module tb;
  import bam_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int DrainWait = 200;

  logic       clk = 0;
  logic       rst = 1;
  logic       valid = 0;
  logic       stall;
  logic [7:0] red = 0;
  logic [7:0] green = 0;
  logic [7:0] blue = 0;
  logic       frame_start = 0;
  logic       out_valid;
  logic       out_stall = 0;
  logic [7:0] block_col, block_row, avg_red, avg_green, avg_blue;
  logic       frame_done;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [1:0] cfg_index = RegWidth;
  logic [9:0] cfg_data = 0;

  int errors, pending, pixels_seen, blocks_seen;
  int cycles = 0;
  int stall_left = 0;
  int cfg_writes = 0;
  bit quiet = 0;

  always #4 clk = ~clk;

  block_average_mosaic_top u_top (.*);

  bam_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 0;
      if (!quiet && $urandom_range(0, 99) < 25)
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic put_pixel(int r, int g, int b, bit fs);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      valid <= 0;
      repeat (gap) @(negedge clk);
    end
    valid <= 1;
    red <= 8'(r);
    green <= 8'(g);
    blue <= 8'(b);
    frame_start <= fs;
    do @(posedge clk); while (stall);
  endtask

  task automatic put_rand(bit fs);
    if ($urandom_range(0, 9) == 0)
      put_pixel($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                $urandom_range(0, 1) * 255, fs);
    else
      put_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), fs);
  endtask

  task automatic drain();
    @(negedge clk);
    valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 10'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    cfg_writes++;
  endtask

  task automatic set_mosaic(int w, int h, int a, int d);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegAcross, a);
    write_reg(RegDown, d);
  endtask

  // n pixels of one flat colour, frame starts on the first
  task automatic put_flat(int n, int v);
    for (int i = 0; i < n; i++) put_pixel(v, v, 255 - v, i == 0);
  endtask

  initial begin
    int w, h, a, d, n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // reset geometry: partial frame, nothing may come out
    quiet = 1;
    put_pixel(0, 255, 0, 1);
    for (int i = 0; i < 9; i++) put_pixel(255, 0, 255, 0);
    quiet = 0;
    drain();

    // zero registers act as one: every pixel is a whole frame
    set_mosaic(0, 0, 0, 0);
    put_pixel(255, 255, 255, 0);
    put_pixel(0, 0, 0, 1);
    put_pixel(255, 0, 128, 0);
    put_pixel(1, 254, 127, 1);
    drain();

    // 2x2 blocks, two across, restart mid-frame
    set_mosaic(2, 2, 2, 1);
    put_pixel(255, 0, 255, 1);
    put_pixel(255, 0, 0, 0);
    put_pixel(0, 255, 255, 0);
    put_pixel(254, 1, 0, 1);
    put_pixel(255, 255, 1, 0);
    for (int i = 0; i < 7; i++) put_rand(0);
    drain();

    // 640-pixel-wide block, widest and tallest frame in blocks
    set_mosaic(640, 1, 1, 1);
    put_flat(640, 255);
    drain();
    set_mosaic(1, 1, 511, 1);
    for (int i = 0; i < 258; i++) put_rand(i == 0);
    drain();
    write_reg(RegAcross, 256);
    write_reg(RegDown, 256);
    write_reg(RegWidth, 1);
    for (int i = 0; i < 20; i++) put_rand(i == 0);
    drain();
    set_mosaic(1, 1, 1, 511);
    for (int i = 0; i < 258; i++) put_rand(i == 0);
    drain();

    // geometry shrunk inside a block: counters carry on, means saturate
    set_mosaic(8, 4, 3, 2);
    for (int i = 0; i < 52; i++) put_pixel(255, 250, 255, i == 0);
    drain();
    write_reg(RegWidth, 2);
    write_reg(RegHeight, 1);
    for (int i = 0; i < 30; i++) put_pixel(255, 255, 200, 0);
    drain();

    // random geometries, mostly clean frames with some restarts as noise
    for (int ph = 0; ph < 6; ph++) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      a = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      d = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      set_mosaic(w, h, a, d);
      quiet = ($urandom_range(0, 4) == 0);
      n = $urandom_range(20, 40);
      if ($urandom_range(0, 5) == 0)
        for (int i = 0; i < n; i++) put_rand(i == 0 || $urandom_range(0, 7) == 0);
      else
        for (int i = 0; i < n; i++) put_rand(i == 0);
      quiet = 0;
      drain();
    end

    $display("Ran %0d pixel and %0d block transactions over %0d register writes,",
             pixels_seen, blocks_seen, cfg_writes);
    $display("including zero, oversized and mid-block geometry changes.");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
